>>> sv/dsd_pkg.sv
// Package for the DAQ event stream deframer.
// Holds the result record, the counter memory request, codes and small helpers.
// No dependencies.
package dsd_pkg;

    localparam logic [2:0] KIND_ACCEPT     = 3'd0;
    localparam logic [2:0] KIND_REJECT     = 3'd1;
    localparam logic [2:0] KIND_HALT_ZERO  = 3'd2;
    localparam logic [2:0] KIND_HALT_BOARD = 3'd3;
    localparam logic [2:0] KIND_HALT_SHORT = 3'd4;
    localparam logic [2:0] KIND_RECORD     = 3'd5;

    localparam logic [1:0] REG_ACQ_MODE     = 2'd0;
    localparam logic [1:0] REG_HEADER_BYTES = 2'd1;
    localparam logic [1:0] REG_RECORD_BYTES = 2'd2;

    localparam logic [2:0] MODE_SPECT        = 3'd1;
    localparam logic [2:0] MODE_SPECT_TIMING = 3'd3;

    localparam logic [7:0]  FIXED_HDR  = 8'd27;
    localparam logic [12:0] GAIN_LIMIT = 13'd4096;
    localparam int          BUF_DEPTH  = 12;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  board_id;
        logic [63:0] trigger_id;
        logic [63:0] trigger_time_bits;
        logic [7:0]  channel_id;
        logic [12:0] low_gain;
        logic [12:0] high_gain;
        logic [31:0] arrival_time;
        logic [15:0] over_threshold_time;
        logic [31:0] board_event_count;
        logic [31:0] rejected_count;
        logic        last;
    } t_result;

    typedef struct packed {
        logic        rd_en;
        logic [7:0]  rd_addr;
        logic        wr_en;
        logic [7:0]  wr_addr;
        logic [31:0] wr_data;
    } t_cnt_req;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

    function automatic logic [12:0] clamp_gain(input logic [15:0] g);
        return (g > {3'd0, GAIN_LIMIT}) ? GAIN_LIMIT : g[12:0];
    endfunction

endpackage

>>> sv/daq_event_stream_deframer.sv
// Top level of the DAQ event stream deframer: configuration registers,
// byte parser and the registered result stage. Depends on dsd_pkg, dsd_parser.
//
// One byte is taken every clock cycle while the result register is free or
// being drained; each byte yields at most one result, which appears in the
// next cycle. The size check completes on the last mask byte, using a popcount accumulated
// over the mask bytes and a per-board counter read from a 16-entry memory
// when the board id byte arrives. After a halt result bytes are taken and
// dropped until reset.
module daq_event_stream_deframer #(
    parameter int NUM_CHANNELS = 64,
    parameter int NUM_BOARDS   = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // board_id, trigger_id, trigger_time_bits, channel_id, low_gain, high_gain,
    // arrival_time, over_threshold_time, board_event_count, rejected_count
    output logic [287:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast,   // last
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data
);
    import dsd_pkg::*;

    logic [2:0] r_acq_mode;
    logic [7:0] r_header_bytes;
    logic [4:0] r_record_bytes;
    logic       r_ov;
    t_result    r_res;
    logic       w_acc;
    logic       w_res_v;
    t_result    w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acq_mode     <= MODE_SPECT;
            r_header_bytes <= FIXED_HDR;
            r_record_bytes <= 5'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ACQ_MODE:     r_acq_mode     <= i_cfg_data[2:0];
                REG_HEADER_BYTES: r_header_bytes <= i_cfg_data;
                REG_RECORD_BYTES: r_record_bytes <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_ov || m_axis_tready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    dsd_parser #(.NUM_CHANNELS(NUM_CHANNELS), .NUM_BOARDS(NUM_BOARDS)) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_acc),
        .i_byte         (s_axis_tdata),
        .i_acq_mode     (r_acq_mode),
        .i_header_bytes (r_header_bytes),
        .i_record_bytes (r_record_bytes),
        .o_res_valid    (w_res_v),
        .o_res          (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_acc) begin
            r_ov <= w_res_v;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_res_v) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_res.kind;
    assign m_axis_tlast  = r_res.last;
    assign m_axis_tdata  = {6'd0, r_res.rejected_count, r_res.board_event_count,
                            r_res.over_threshold_time, r_res.arrival_time,
                            r_res.high_gain, r_res.low_gain, r_res.channel_id,
                            r_res.trigger_time_bits, r_res.trigger_id, r_res.board_id};

endmodule

>>> sv/dsd_count_mem.sv
// Per-board accepted event counter memory, registered read.
// Valid bits make never-written entries read as zero after reset.
// Depends on dsd_pkg.
module dsd_count_mem #(
    parameter int NUM_BOARDS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dsd_pkg::t_cnt_req i_req,
    output logic [31:0]       o_rd_data
);
    import dsd_pkg::*;

    localparam int AW = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;

    logic [31:0]           r_mem [NUM_BOARDS];
    logic [NUM_BOARDS-1:0] r_vld;
    logic [31:0]           r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd <= r_vld[i_req.rd_addr[AW-1:0]] ? r_mem[i_req.rd_addr[AW-1:0]] : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr[AW-1:0]] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd;

endmodule

>>> sv/dsd_parser.sv
// Byte parser of the event stream: header fields, size check, record assembly.
// Reads and updates per-board counters in dsd_count_mem. Depends on dsd_pkg.
module dsd_parser #(
    parameter int NUM_CHANNELS = 64,
    parameter int NUM_BOARDS   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_byte,
    input  logic [2:0]       i_acq_mode,
    input  logic [7:0]       i_header_bytes,
    input  logic [4:0]       i_record_bytes,
    output logic             o_res_valid,
    output dsd_pkg::t_result o_res
);
    import dsd_pkg::*;

    localparam logic [63:0] CH_MASK = (NUM_CHANNELS >= 64) ? {64{1'b1}} :
                                      ((64'd1 << NUM_CHANNELS) - 64'd1);
    localparam logic [8:0]  NB9     = 9'(NUM_BOARDS);

    logic [15:0] r_pos, n_pos;
    logic [15:0] r_size, n_size;
    logic [7:0]  r_board, n_board;
    logic [63:0] r_time, n_time;
    logic [63:0] r_trig, n_trig;
    logic [6:0]  r_pop, n_pop;
    logic [6:0]  r_rl, n_rl;
    logic        r_skip, n_skip;
    logic        r_halt, n_halt;
    logic [3:0]  r_off, n_off;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_rej, n_rej;
    logic [7:0]  r_buf [BUF_DEPTH];
    logic [7:0]  n_buf [BUF_DEPTH];

    logic [4:0]  w_rec;
    logic [7:0]  w_hdr;
    logic [2:0]  w_i3, w_i11, w_i19;
    logic [12:0] w_exp;
    logic        w_end;
    logic        w_rec_last;
    logic [31:0] w_rd;
    t_cnt_req    w_req;
    t_result     w_res;
    logic        w_res_v;

    dsd_count_mem #(.NUM_BOARDS(NUM_BOARDS)) u_cnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_rd_data (w_rd)
    );

    assign w_rec      = (i_record_bytes == 5'd0) ? 5'd1 : i_record_bytes;
    assign w_hdr      = (i_header_bytes < FIXED_HDR) ? FIXED_HDR : i_header_bytes;
    assign w_i3       = 3'(r_pos - 16'd3);
    assign w_i11      = 3'(r_pos - 16'd11);
    assign w_i19      = 3'(r_pos - 16'd19);
    assign w_rec_last = ({1'b0, r_off} == (w_rec - 5'd1));

    always_comb begin
        n_pos   = r_pos;
        n_size  = r_size;
        n_board = r_board;
        n_time  = r_time;
        n_trig  = r_trig;
        n_pop   = r_pop;
        n_rl    = r_rl;
        n_skip  = r_skip;
        n_halt  = r_halt;
        n_off   = r_off;
        n_cnt   = r_cnt;
        n_rej   = r_rej;
        n_buf   = r_buf;
        w_exp   = '0;
        w_end   = 1'b0;
        w_req   = '0;
        w_res_v = 1'b0;
        w_res   = '0;

        if (i_en && !r_halt) begin
            n_pos = r_pos + 16'd1;
            if (r_pos < {8'd0, FIXED_HDR}) begin
                if (r_pos == 16'd0) begin
                    n_size = {8'd0, i_byte};
                    n_time = '0;
                    n_trig = '0;
                    n_pop  = '0;
                end else if (r_pos == 16'd1) begin
                    n_size[15:8] = i_byte;
                end else if (r_pos == 16'd2) begin
                    n_board       = i_byte;
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = i_byte;
                end else if (r_pos < 16'd11) begin
                    n_time[8*w_i3 +: 8] = i_byte;
                end else if (r_pos < 16'd19) begin
                    n_trig[8*w_i11 +: 8] = i_byte;
                end else begin
                    n_pop = r_pop + {3'd0, pop8(i_byte & CH_MASK[8*w_i19 +: 8])};
                    if (r_pos == 16'd26) begin
                        n_off = '0;
                        w_exp = 13'(w_hdr) + 13'(12'(n_pop) * 12'(w_rec));
                        w_res_v                 = 1'b1;
                        w_res.board_id          = r_board;
                        w_res.trigger_id        = r_trig;
                        w_res.trigger_time_bits = r_time;
                        w_res.last              = 1'b1;
                        if (r_size == 16'd0) begin
                            n_halt     = 1'b1;
                            w_res.kind = KIND_HALT_ZERO;
                        end else if ({1'b0, r_board} >= NB9) begin
                            n_halt     = 1'b1;
                            w_res.kind = KIND_HALT_BOARD;
                        end else if (r_size < {8'd0, w_hdr}) begin
                            n_halt     = 1'b1;
                            w_res.kind = KIND_HALT_SHORT;
                        end else if (r_size != {3'd0, w_exp}) begin
                            n_rej      = r_rej + 32'd1;
                            n_skip     = 1'b1;
                            n_rl       = '0;
                            w_res.kind = KIND_REJECT;
                            w_end      = 1'b1;
                        end else begin
                            n_cnt         = w_rd + 32'd1;
                            w_req.wr_en   = 1'b1;
                            w_req.wr_addr = r_board;
                            w_req.wr_data = n_cnt;
                            n_rl   = (i_acq_mode == MODE_SPECT ||
                                      i_acq_mode == MODE_SPECT_TIMING) ? n_pop : 7'd0;
                            n_skip = 1'b0;
                            w_res.kind              = KIND_ACCEPT;
                            w_res.board_event_count = n_cnt;
                            w_res.last              = (n_rl == 7'd0);
                            w_end                   = 1'b1;
                        end
                        w_res.rejected_count = n_rej;
                    end
                end
            end else begin
                w_end = 1'b1;
                if (r_pos >= {8'd0, w_hdr}) begin
                    n_off = w_rec_last ? 4'd0 : r_off + 4'd1;
                    if (!r_skip && r_rl != 7'd0) begin
                        if (r_off == 4'd0) begin
                            for (int i = 0; i < BUF_DEPTH; i++) begin
                                n_buf[i] = 8'd0;
                            end
                        end
                        if (r_off < 4'(BUF_DEPTH)) begin
                            n_buf[r_off] = i_byte;
                        end
                        if (w_rec_last) begin
                            n_rl    = r_rl - 7'd1;
                            w_res_v = 1'b1;
                            w_res.kind              = KIND_RECORD;
                            w_res.board_id          = r_board;
                            w_res.trigger_id        = r_trig;
                            w_res.trigger_time_bits = r_time;
                            w_res.board_event_count = r_cnt;
                            w_res.rejected_count    = r_rej;
                            w_res.last              = (n_rl == 7'd0);
                            w_res.channel_id        = n_buf[0];
                            w_res.low_gain          = clamp_gain({n_buf[3], n_buf[2]});
                            w_res.high_gain         = clamp_gain({n_buf[5], n_buf[4]});
                            if (i_acq_mode == MODE_SPECT_TIMING) begin
                                w_res.arrival_time = {n_buf[9], n_buf[8], n_buf[7], n_buf[6]};
                                w_res.over_threshold_time = {n_buf[11], n_buf[10]};
                            end
                        end
                    end
                end
            end
            if (w_end && n_pos == r_size) begin
                n_pos  = '0;
                n_skip = 1'b0;
                n_rl   = '0;
                n_off  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_size <= '0;
            r_rl   <= '0;
            r_skip <= 1'b0;
            r_halt <= 1'b0;
            r_off  <= '0;
            r_cnt  <= '0;
            r_rej  <= '0;
            r_pop  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_size <= n_size;
            r_rl   <= n_rl;
            r_skip <= n_skip;
            r_halt <= n_halt;
            r_off  <= n_off;
            r_cnt  <= n_cnt;
            r_rej  <= n_rej;
            r_pop  <= n_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_board <= n_board;
        r_time  <= n_time;
        r_trig  <= n_trig;
        r_buf   <= n_buf;
    end

    assign o_res_valid = w_res_v;
    assign o_res       = w_res;

endmodule

>>> sv/dsd_checker.sv
// Port-level checks of the deframer result stream, bound to the top level.
// Depends on dsd_pkg.
module dsd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [287:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tlast
);
    import dsd_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= KIND_RECORD)
        else $error("undefined result kind");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_REJECT || m_axis_tuser == KIND_HALT_ZERO ||
            m_axis_tuser == KIND_HALT_BOARD || m_axis_tuser == KIND_HALT_SHORT)
            |-> m_axis_tlast)
        else $error("reject or halt result without last");

    a_halt_zero_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_ACCEPT && m_axis_tuser != KIND_RECORD
            |-> m_axis_tdata[249:218] == 32'd0)
        else $error("board count on reject or halt result");

endmodule

bind daq_event_stream_deframer dsd_checker u_dsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/sv/tb.sv
// Self-checking bench for daq_event_stream_deframer: builds event byte streams,
// predicts every result in the bench and compares kind, last and data of each output result.
// Depends on dsd_pkg and the deframer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dsd_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'd0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [287:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_index = 2'd0;
    logic [7:0]   i_cfg_data = 8'd0;

    daq_event_stream_deframer dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // shadow deframer state
    logic [2:0]  cur_mode;
    logic [7:0]  cur_hdr;
    logic [4:0]  cur_rec;
    logic [15:0] pos_q;
    logic [15:0] size_q;
    logic [7:0]  board_q;
    logic [63:0] tbits_q, trig_q, mask_q;
    logic [7:0]  rbuf [BUF_DEPTH];
    logic [6:0]  recs_left;
    logic        skip_q, halt_q;
    logic [31:0] board_cnt [16];
    logic [31:0] reject_cnt;

    logic [7:0]  byte_q[$];
    t_result     expected_q[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    int          errors = 0;
    int          results_seen = 0;
    int          bytes_sent = 0;

    function automatic t_result base_result(logic [2:0] kind, logic [31:0] cnt, logic last);
        t_result r;
        r = '0;
        r.kind = kind;
        r.board_id = board_q;
        r.trigger_id = trig_q;
        r.trigger_time_bits = tbits_q;
        r.board_event_count = cnt;
        r.rejected_count = reject_cnt;
        r.last = last;
        return r;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        byte_q = {byte_q, b};
    endfunction

    function automatic void put_result(t_result r);
        expected_q = {expected_q, r};
    endfunction

    function automatic logic [12:0] gain_of(logic [15:0] g);
        return (g > 16'd4096) ? 13'd4096 : g[12:0];
    endfunction

    task automatic predict_byte(logic [7:0] b);
        int hdr, rec, p, pop, off;
        t_result r;
        logic emit;
        hdr = (cur_hdr < 27) ? 27 : cur_hdr;
        rec = (cur_rec == 0) ? 1 : cur_rec;
        p = pos_q;
        if (halt_q) return;
        if (p < 27) begin
            if (p == 0) begin
                size_q = {8'd0, b}; tbits_q = '0; trig_q = '0; mask_q = '0;
            end else if (p == 1) size_q[15:8] = b;
            else if (p == 2) board_q = b;
            else if (p < 11) tbits_q[8*(p-3) +: 8] = b;
            else if (p < 19) trig_q[8*(p-11) +: 8] = b;
            else mask_q[8*(p-19) +: 8] = b;
            pos_q = 16'(p + 1);
            if (p != 26) return;
            pop = $countones(mask_q);
            emit = (cur_mode == MODE_SPECT || cur_mode == MODE_SPECT_TIMING);
            if (size_q == 0) begin
                halt_q = 1; put_result(base_result(KIND_HALT_ZERO, 0, 1)); return;
            end
            if (board_q >= 16) begin
                halt_q = 1; put_result(base_result(KIND_HALT_BOARD, 0, 1)); return;
            end
            if (size_q < hdr) begin
                halt_q = 1; put_result(base_result(KIND_HALT_SHORT, 0, 1)); return;
            end
            if (size_q != hdr + pop * rec) begin
                reject_cnt++; skip_q = 1; recs_left = 0;
                put_result(base_result(KIND_REJECT, 0, 1));
            end else begin
                board_cnt[board_q[3:0]]++;
                recs_left = emit ? 7'(pop) : 7'd0;
                skip_q = 0;
                put_result(base_result(KIND_ACCEPT, board_cnt[board_q[3:0]],
                                       recs_left == 0));
            end
        end else begin
            pos_q = 16'(p + 1);
            if (!skip_q && recs_left > 0 && p >= hdr) begin
                off = (p - hdr) % rec;
                if (off == 0) foreach (rbuf[i]) rbuf[i] = 8'd0;
                if (off < BUF_DEPTH) rbuf[off] = b;
                if (off == rec - 1) begin
                    recs_left--;
                    r = base_result(KIND_RECORD, board_cnt[board_q[3:0]], recs_left == 0);
                    r.channel_id = rbuf[0];
                    r.low_gain = gain_of({rbuf[3], rbuf[2]});
                    r.high_gain = gain_of({rbuf[5], rbuf[4]});
                    if (cur_mode == MODE_SPECT_TIMING) begin
                        r.arrival_time = {rbuf[9], rbuf[8], rbuf[7], rbuf[6]};
                        r.over_threshold_time = {rbuf[11], rbuf[10]};
                    end
                    put_result(r);
                end
            end
        end
        if (pos_q == size_q) begin
            pos_q = 0; skip_q = 0; recs_left = 0;
        end
    endtask

    // build one event; flavor 0 good, 1 size mismatch, 2 random size noise
    task automatic queue_event(int board, int nchan, int flavor);
        logic [63:0] m;
        int hdr, rec, sz, k, idx;
        hdr = (cur_hdr < 27) ? 27 : cur_hdr;
        rec = (cur_rec == 0) ? 1 : cur_rec;
        m = '0;
        for (k = 0; k < nchan; k++) begin
            idx = $urandom_range(63);
            while (m[idx]) idx = (idx + 1) % 64;
            m[idx] = 1'b1;
        end
        sz = hdr + nchan * rec;
        if (flavor == 1) sz = sz + ((nchan == 0 || $urandom_range(1)) ? 1 : -1);
        if (flavor == 2) sz = hdr + $urandom_range(200);
        for (k = 0; k < sz; k++) begin
            if (k < 2) put_byte(sz[8*k +: 8]);
            else if (k == 2) put_byte(board[7:0]);
            else if (k >= 19 && k < 27) put_byte(m[8*(k-19) +: 8]);
            else if (k >= hdr && ($urandom_range(3) == 0))
                put_byte($urandom_range(1) ? 8'hff : 8'h10);
            else put_byte(8'($urandom_range(255)));
        end
    endtask

    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            predict_byte(s_axis_tdata);
            void'(byte_q.pop_front());
            bytes_sent++;
        end
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if ((s_axis_tvalid && s_axis_tready) || !s_axis_tvalid) begin
            if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= byte_q[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result kind=%0d data=%h", $realtime, m_axis_tuser,
                         m_axis_tdata);
            end else begin
                exp_r = expected_q.pop_front();
                if (m_axis_tuser !== exp_r.kind || m_axis_tlast !== exp_r.last
                        || m_axis_tdata !== {6'd0, exp_r.rejected_count,
                        exp_r.board_event_count,
                        exp_r.over_threshold_time, exp_r.arrival_time, exp_r.high_gain,
                        exp_r.low_gain, exp_r.channel_id, exp_r.trigger_time_bits,
                        exp_r.trigger_id, exp_r.board_id}) begin
                    errors++;
                    $display("%0t mismatch: expected kind=%0d last=%0b data=%h", $realtime,
                             exp_r.kind, exp_r.last, {6'd0, exp_r.rejected_count,
                             exp_r.board_event_count, exp_r.over_threshold_time,
                             exp_r.arrival_time, exp_r.high_gain, exp_r.low_gain,
                             exp_r.channel_id, exp_r.trigger_time_bits, exp_r.trigger_id,
                             exp_r.board_id});
                    $display("%0t          actual   kind=%0d last=%0b data=%h", $realtime,
                             m_axis_tuser, m_axis_tlast, m_axis_tdata);
                end
            end
        end
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ACQ_MODE) cur_mode = val[2:0];
        else if (idx == REG_HEADER_BYTES) cur_hdr = val;
        else cur_rec = val[4:0];
    endtask

    task automatic drain();
        while (byte_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_config(int mode, int hdr, int rec);
        drain();
        write_reg(REG_ACQ_MODE, 8'(mode));
        write_reg(REG_HEADER_BYTES, 8'(hdr));
        write_reg(REG_RECORD_BYTES, 8'(rec));
    endtask

    task automatic random_events(int nbytes);
        int start;
        start = bytes_sent + byte_q.size();
        while (bytes_sent + byte_q.size() - start < nbytes) begin
            case ($urandom_range(9))
                0: queue_event($urandom_range(15), $urandom_range(3), 1);
                1: queue_event($urandom_range(15), $urandom_range(2), 2);
                default: queue_event($urandom_range(15), $urandom_range(4), 0);
            endcase
        end
    endtask

    initial begin
        int k;
        cur_mode = 3'd1; cur_hdr = 8'd27; cur_rec = 5'd6;
        pos_q = 0; size_q = 0; board_q = 0; tbits_q = 0; trig_q = 0; mask_q = 0;
        recs_left = 0; skip_q = 0; halt_q = 0; reject_cnt = 0;
        foreach (board_cnt[i]) board_cnt[i] = 0;
        foreach (rbuf[i]) rbuf[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset setting, then extremes
        queue_event(0, 0, 0);
        queue_event(15, 2, 0);
        queue_event(3, 1, 1);
        set_config(3, 27, 12);
        queue_event(7, 2, 0);
        set_config(3, 40, 16);
        queue_event(1, 1, 0);
        set_config(2, 27, 1);
        queue_event(2, 3, 0);
        set_config(4, 30, 6);
        queue_event(2, 1, 0);
        set_config(1, 255, 1);
        queue_event(9, 64, 0);
        set_config(0, 10, 0);
        queue_event(4, 2, 0);

        // random phases with idling mixes
        send_idle_pct = 0;  recv_stall_pct = 0;
        set_config(1, 27, 6);   random_events(110);
        send_idle_pct = 63; set_config(3, 27, 12); random_events(110);
        send_idle_pct = 0;  recv_stall_pct = 63;
        set_config(3, 32, 14);  random_events(110);
        send_idle_pct = 7;  recv_stall_pct = 7;
        set_config(1, 28, 4);   random_events(90);

        // long receiver hold-off while bytes keep coming
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        random_events(50);

        // halt case: a zero-size event with no reset after it, so the deframer stays halted
        set_config(1, 27, 6);
        put_byte(8'd0); put_byte(8'd0);
        for (k = 2; k < 27; k++) put_byte(8'($urandom_range(255)));
        for (k = 0; k < 20; k++) put_byte(8'($urandom_range(255)));
        drain();

        $display("Covered %0d bytes and %0d results across all acquisition modes,",
                 bytes_sent, results_seen);
        $display("idle and stall mixes, a long output hold-off, rejects and a zero-size halt.");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
